[src/pmt_pkg.sv]
package pmt_pkg;

    // Field widths
    localparam int OP_W    = 2;
    localparam int SEQ_W   = 16;
    localparam int TIME_W  = 32;
    localparam int RETRY_W = 8;
    localparam int LEN_W   = 8;
    localparam int STAT_W  = 2;
    localparam int HELD_W  = 5;

    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 56;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam logic [LEN_W-1:0] MAX_LEN_RST = 8'd64;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_TOO_LONG  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

    // One table entry as held in a cell
    typedef struct packed {
        logic               valid;
        logic [SEQ_W-1:0]   seq;
        logic [TIME_W-1:0]  arr_time;
        logic [RETRY_W-1:0] retry;
        logic [LEN_W-1:0]   len;
    } t_entry;

    // Search token that ripples down the chain, one cell per cycle
    typedef struct packed {
        logic               tok;
        logic               found;
        logic [TIME_W-1:0]  arr_time;
        logic [RETRY_W-1:0] retry;
        logic [LEN_W-1:0]   len;
    } t_pkt;

    // Controls broadcast to every cell
    typedef struct packed {
        logic               add_en;
        logic               clr;
        logic               rem;
        logic [SEQ_W-1:0]   key;
        logic [TIME_W-1:0]  arr_time;
        logic [RETRY_W-1:0] retry;
        logic [LEN_W-1:0]   len;
    } t_ctl;

endpackage

[src/pmt_cell.sv]
module pmt_cell
    import pmt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_ctl   i_ctl,
    input  logic   i_prev_valid,   // valid bit of the older neighbor
    input  t_entry i_next,         // contents of the younger neighbor
    input  t_pkt   i_pkt,          // token from the older neighbor
    output t_pkt   o_pkt,
    output t_entry o_entry
);

    t_entry r_ent;
    t_pkt   r_pkt;
    t_pkt   n_pkt;
    logic   w_match;
    logic   w_shift;
    logic   w_add;

    // First match along the chain claims the token
    assign w_match = i_pkt.tok && !i_pkt.found && r_ent.valid && (r_ent.seq == i_ctl.key);
    // On remove, every cell from the match onward pulls its younger neighbor
    assign w_shift = i_ctl.rem && i_pkt.tok && (i_pkt.found || w_match);
    // Append lands in the first free cell
    assign w_add   = i_ctl.add_en && !r_ent.valid && i_prev_valid;

    always_comb begin
        n_pkt = i_pkt;
        if (w_match) begin
            n_pkt.found    = 1'b1;
            n_pkt.arr_time = r_ent.arr_time;
            n_pkt.retry    = r_ent.retry;
            n_pkt.len      = r_ent.len;
        end
    end

    // Only the valid bit is reset; entry fields are written by shift or add
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.valid <= 1'b0;
        end else if (i_ctl.clr) begin
            r_ent.valid <= 1'b0;
        end else if (w_shift) begin
            r_ent <= i_next;
        end else if (w_add) begin
            r_ent.valid    <= 1'b1;
            r_ent.seq      <= i_ctl.key;
            r_ent.arr_time <= i_ctl.arr_time;
            r_ent.retry    <= i_ctl.retry;
            r_ent.len      <= i_ctl.len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt <= '0;
        end else begin
            r_pkt <= n_pkt;
        end
    end

    assign o_pkt   = r_pkt;
    assign o_entry = r_ent;

endmodule

[src/pending_message_table_top.sv]
// Channel  | Dir | Handshake          | Payload
// s_       | in  | s_tvalid/s_tready  | s_tuser: opcode; s_tdata: seq, time, retry, len
// m_       | out | m_tvalid/m_tready  | m_tdata: status, hit, time, retry, len, held count
// cfg      | in  | i_cfg_we           | i_cfg_wdata: max_payload_len
//
// Add and clear act and load their result in the execute state; find and
// remove launch a search token that ripples one cell per cycle down the chain
// of TABLE_DEPTH cells, and load their result once it leaves the last cell.
// One item is in work at a time.
// A new item is taken while a finished result still waits on the m_ side;
// a stalled m_ side holds the next item at its final step.
// Reset (i_rst_n low, synchronous) empties the table and sets the length
// limit to 64.
module pending_message_table_top
    import pmt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // config
    input  logic                   i_cfg_we,
    input  logic [LEN_W-1:0]       i_cfg_wdata,   // max_payload_len
    // input items
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_DATA_W-1:0]   s_tdata,       // seq_num[15:0], arrival_time[47:16],
                                                  // retry_budget[55:48], payload_len[63:56]
    input  logic [IN_USER_W-1:0]   s_tuser,       // opcode[1:0]
    // result items
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata        // status[1:0], hit[2], hit_time[34:3],
                                                  // hit_retry[42:35], hit_len[50:43],
                                                  // held_count[55:51]
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]         r_state;
    logic [1:0]         n_state;

    // Latched item
    logic [OP_W-1:0]    r_op;
    logic [SEQ_W-1:0]   r_seq;
    logic [TIME_W-1:0]  r_time;
    logic [RETRY_W-1:0] r_retry;
    logic [LEN_W-1:0]   r_len;

    logic [LEN_W-1:0]   r_max_len;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;

    // Search outcome captured from the chain's tail
    t_pkt               r_res;

    // Output register
    logic               r_m_valid;
    logic [STAT_W-1:0]  r_m_status;
    logic               r_m_hit;
    logic [TIME_W-1:0]  r_m_time;
    logic [RETRY_W-1:0] r_m_retry;
    logic [LEN_W-1:0]   r_m_len;
    logic [HELD_W-1:0]  r_m_held;

    logic               w_accept;
    logic               w_out_free;
    logic               w_out_load;
    logic               w_len_ok;
    logic               w_full;
    logic [STAT_W-1:0]  w_status;
    logic               w_hit;

    t_ctl               w_ctl;
    t_pkt               w_launch;
    t_pkt               w_pkt [TABLE_DEPTH];
    t_entry             w_ent [TABLE_DEPTH];

    assign s_tready   = (r_state == S_IDLE);
    assign w_accept   = s_tvalid && s_tready;
    assign w_out_free = !r_m_valid || m_tready;
    assign w_len_ok   = (r_len <= r_max_len);
    assign w_full     = (r_count == CNT_W'(TABLE_DEPTH));

    // Broadcast controls; add and clear fire only once the result can be stored
    always_comb begin
        w_ctl.add_en   = (r_state == S_EXEC) && (r_op == OP_ADD) && w_out_free
                         && w_len_ok && !w_full;
        w_ctl.clr      = (r_state == S_EXEC) && (r_op == OP_CLEAR) && w_out_free;
        w_ctl.rem      = (r_op == OP_REMOVE);
        w_ctl.key      = r_seq;
        w_ctl.arr_time = r_time;
        w_ctl.retry    = r_retry;
        w_ctl.len      = r_len;
    end

    // Launch the search token into cell 0
    always_comb begin
        w_launch     = '0;
        w_launch.tok = (r_state == S_EXEC) && ((r_op == OP_FIND) || (r_op == OP_REMOVE));
    end

    // Chain of cells, oldest entry in cell 0
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        t_pkt   w_pin;
        t_entry w_nxt;
        logic   w_pv;

        if (g == 0) begin : g_head
            assign w_pin = w_launch;
            assign w_pv  = 1'b1;
        end else begin : g_body
            assign w_pin = w_pkt[g-1];
            assign w_pv  = w_ent[g-1].valid;
        end

        if (g == TABLE_DEPTH - 1) begin : g_tail
            assign w_nxt = '0;
        end else begin : g_inner
            assign w_nxt = w_ent[g+1];
        end

        pmt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_prev_valid (w_pv),
            .i_next       (w_nxt),
            .i_pkt        (w_pin),
            .o_pkt        (w_pkt[g]),
            .o_entry      (w_ent[g])
        );
    end

    // Sequencer and result formation
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        w_out_load = 1'b0;
        w_status   = ST_OK;
        w_hit      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if ((r_op == OP_FIND) || (r_op == OP_REMOVE)) begin
                    n_state = S_WALK;
                end else if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                    if (r_op == OP_CLEAR) begin
                        n_count = '0;
                    end else if (!w_len_ok) begin
                        w_status = ST_TOO_LONG;
                    end else if (w_full) begin
                        w_status = ST_FULL;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
            end
            S_WALK: begin
                if (w_pkt[TABLE_DEPTH-1].tok) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                    if (!r_res.found) begin
                        w_status = ST_NOT_FOUND;
                    end else if (r_op == OP_REMOVE) begin
                        n_count = r_count - CNT_W'(1);
                    end else begin
                        w_hit = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_max_len <= MAX_LEN_RST;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_max_len <= i_cfg_wdata;
            end
            if (w_out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Hold the item while it is in work
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= s_tuser[OP_W-1:0];
            r_seq   <= s_tdata[15:0];
            r_time  <= s_tdata[47:16];
            r_retry <= s_tdata[55:48];
            r_len   <= s_tdata[63:56];
        end
    end

    // Capture the token as it leaves the last cell
    always_ff @(posedge i_clk) begin
        if ((r_state == S_WALK) && w_pkt[TABLE_DEPTH-1].tok) begin
            r_res <= w_pkt[TABLE_DEPTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_m_status <= w_status;
            r_m_hit    <= w_hit;
            r_m_time   <= w_hit ? r_res.arr_time : '0;
            r_m_retry  <= w_hit ? r_res.retry : '0;
            r_m_len    <= w_hit ? r_res.len : '0;
            r_m_held   <= HELD_W'(n_count);
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {r_m_held, r_m_len, r_m_retry, r_m_time, r_m_hit, r_m_status};

endmodule

[src/pmt_checker.sv]
module pmt_checker
    import pmt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata
);

    // A hit only comes with an ok status
    a_hit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tdata[2]) |-> (m_tdata[1:0] == ST_OK))
        else $error("hit with non-ok status");

    // Without a hit the entry fields are zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tdata[2]) |-> (m_tdata[50:3] == '0))
        else $error("entry fields set without hit");

    // Held count never exceeds the table depth
    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (int'(m_tdata[55:51]) <= TABLE_DEPTH))
        else $error("held count above table depth");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

endmodule

bind pending_message_table_top pmt_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_pmt_checker (.*);

[sim/pmt_checker.sv]
`timescale 1ns / 100ps

module pmt_scoreboard
    import pmt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [LEN_W-1:0]      i_cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [IN_USER_W-1:0]  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_results,
    output int                    o_hits
);

    typedef struct {
        logic [STAT_W-1:0]  status;
        logic               hit;
        logic [TIME_W-1:0]  hit_time;
        logic [RETRY_W-1:0] hit_retry;
        logic [LEN_W-1:0]   hit_len;
        logic [HELD_W-1:0]  held;
    } t_table_result;

    // Shadow copy of the message table, oldest entry in slot 0
    logic [SEQ_W-1:0]   entry_seq   [TABLE_DEPTH];
    logic [TIME_W-1:0]  entry_time  [TABLE_DEPTH];
    logic [RETRY_W-1:0] entry_retry [TABLE_DEPTH];
    logic [LEN_W-1:0]   entry_len   [TABLE_DEPTH];
    int                 entry_count;
    logic [LEN_W-1:0]   len_limit;

    t_table_result pending_results[$];

    // Oldest slot holding the key, or -1
    function automatic int oldest_match(logic [SEQ_W-1:0] key);
        for (int i = 0; i < entry_count; i++) begin
            if (entry_seq[i] == key)
                return i;
        end
        return -1;
    endfunction

    function automatic t_table_result predict_table_op(logic [OP_W-1:0] op,
                                                       logic [SEQ_W-1:0] seq,
                                                       logic [TIME_W-1:0] tm,
                                                       logic [RETRY_W-1:0] rty,
                                                       logic [LEN_W-1:0] len);
        t_table_result res;
        int pos;
        res = '{status: ST_OK, hit: 1'b0, hit_time: '0, hit_retry: '0,
                hit_len: '0, held: '0};
        case (op)
            OP_ADD: begin
                // length check wins over the full check
                if (len > len_limit) begin
                    res.status = ST_TOO_LONG;
                end else if (entry_count >= TABLE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    entry_seq[entry_count]   = seq;
                    entry_time[entry_count]  = tm;
                    entry_retry[entry_count] = rty;
                    entry_len[entry_count]   = len;
                    entry_count++;
                end
            end
            OP_FIND: begin
                pos = oldest_match(seq);
                if (pos < 0) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    res.hit       = 1'b1;
                    res.hit_time  = entry_time[pos];
                    res.hit_retry = entry_retry[pos];
                    res.hit_len   = entry_len[pos];
                end
            end
            OP_REMOVE: begin
                pos = oldest_match(seq);
                if (pos < 0) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    // close the gap: younger entries move down one slot
                    for (int i = pos; i < entry_count - 1; i++) begin
                        entry_seq[i]   = entry_seq[i+1];
                        entry_time[i]  = entry_time[i+1];
                        entry_retry[i] = entry_retry[i+1];
                        entry_len[i]   = entry_len[i+1];
                    end
                    entry_count--;
                end
            end
            OP_CLEAR: begin
                entry_count = 0;
            end
        endcase
        res.held = entry_count[HELD_W-1:0];
        return res;
    endfunction

    function automatic int field_bad(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_table_result want;
        int bad;
        if (!i_rst_n) begin
            entry_count  = 0;
            len_limit    = MAX_LEN_RST;
            o_fail_count = 0;
            o_results    = 0;
            o_hits       = 0;
            pending_results.delete();
        end else begin
            if (i_cfg_we)
                len_limit = i_cfg_wdata;
            // check the result before queuing a new item, so a stray result
            // never pairs with an item taken on the same edge
            if (m_tvalid && m_tready) begin
                o_results++;
                if (pending_results.size() == 0) begin
                    $error("result item with no operation outstanding");
                    o_fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    bad  = field_bad("status", 32'(want.status), 32'(m_tdata[1:0]));
                    bad += field_bad("hit", 32'(want.hit), 32'(m_tdata[2]));
                    bad += field_bad("hit_time", want.hit_time, m_tdata[34:3]);
                    bad += field_bad("hit_retry", 32'(want.hit_retry),
                                     32'(m_tdata[42:35]));
                    bad += field_bad("hit_len", 32'(want.hit_len), 32'(m_tdata[50:43]));
                    bad += field_bad("held_count", 32'(want.held), 32'(m_tdata[55:51]));
                    if (bad != 0)
                        o_fail_count++;
                    if (want.hit)
                        o_hits++;
                end
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(predict_table_op(s_tuser, s_tdata[15:0],
                                                           s_tdata[47:16],
                                                           s_tdata[55:48],
                                                           s_tdata[63:56]));
        end
        o_pending = pending_results.size();
    end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top
    import pmt_pkg::*;
();

    localparam int DEPTH          = TABLE_DEPTH_DEF;
    // Slowest item is a search down the whole chain; random stalls on either
    // side add to it. This limit is many times the longest correct silence.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 85;
    localparam int PHASES         = 6;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [LEN_W-1:0]      i_cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;     // seq_num, arrival_time, retry_budget, payload_len
    logic [IN_USER_W-1:0]  s_tuser;     // opcode
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;     // status, hit, hit_time, hit_retry, hit_len, held_count

    int  fail_count;
    int  pending;
    int  results;
    int  hits;
    int  items_sent;
    int  limits_used;
    int  stall_cycles;
    // high while neither side inserts idle cycles
    bit  calm;

    pending_message_table_top #(.TABLE_DEPTH(DEPTH)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    pmt_scoreboard #(.TABLE_DEPTH(DEPTH)) u_scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results),
        .o_hits       (hits)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Result side: drop ready about 30% of the time, except in calm stretches.
    always @(negedge i_clk) begin
        m_tready = calm || ($urandom_range(99) >= 30);
    end

    // Watchdog: end the run if nothing moves on either side for too long.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Present one item and hold it until the block takes it. Entered and
    // left just after a falling edge; valid stays high on return, so the
    // caller either presents the next item right away or lowers valid.
    task automatic send_op(input logic [OP_W-1:0] op, input logic [SEQ_W-1:0] seq,
                           input logic [TIME_W-1:0] tm, input logic [RETRY_W-1:0] rty,
                           input logic [LEN_W-1:0] len);
        if (!calm) begin
            while ($urandom_range(99) < 30) begin
                s_tvalid = 1'b0;
                @(negedge i_clk);
            end
        end
        s_tuser  = op;
        s_tdata  = {len, rty, tm, seq};
        s_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Change the length limit only once the block has drained.
    task automatic program_len_limit(input logic [LEN_W-1:0] value);
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        limits_used++;
    endtask

    // Mostly sequences against a small pool of keys so find and remove hit,
    // with duplicates; the rest is arbitrary keys and oversize lengths.
    task automatic random_op(input logic [LEN_W-1:0] lim, input logic [SEQ_W-1:0] base);
        int                 r;
        logic [OP_W-1:0]    op;
        logic [SEQ_W-1:0]   seq;
        logic [LEN_W-1:0]   len;
        r = $urandom_range(99);
        if (r < 44)
            op = OP_ADD;
        else if (r < 68)
            op = OP_FIND;
        else if (r < 96)
            op = OP_REMOVE;
        else
            op = OP_CLEAR;
        if ($urandom_range(99) < 75)
            seq = base + SEQ_W'($urandom_range(5));
        else
            seq = SEQ_W'($urandom);
        if ($urandom_range(99) < 75)
            len = LEN_W'($urandom_range(lim));
        else
            len = LEN_W'($urandom_range(255));
        send_op(op, seq, $urandom, RETRY_W'($urandom_range(255)), len);
    endtask

    initial begin
        logic [LEN_W-1:0] limit_plan [PHASES];
        logic [SEQ_W-1:0] key_base;

        // inputs known from time zero; ready follows at the first falling edge
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = OP_ADD;
        calm         = 1'b0;
        items_sent   = 0;
        limits_used  = 1;

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part at the reset length limit of 64.
        // Lookups on an empty table miss.
        send_op(OP_FIND, 16'h0005, 32'h0, 8'h0, 8'h0);
        send_op(OP_REMOVE, 16'h0005, 32'h0, 8'h0, 8'h0);
        // field extremes; length exactly at the limit is accepted
        send_op(OP_ADD, 16'h0000, 32'h0000_0000, 8'h00, 8'd0);
        send_op(OP_ADD, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 8'd64);
        // one above the limit is refused
        send_op(OP_ADD, 16'h1234, 32'hAAAA_5555, 8'h01, 8'd65);
        // duplicate keys: find and remove act on the older one
        send_op(OP_ADD, 16'h1234, 32'h1111_1111, 8'h11, 8'd10);
        send_op(OP_ADD, 16'h1234, 32'h2222_2222, 8'h22, 8'd20);
        send_op(OP_FIND, 16'h1234, 32'h0, 8'h0, 8'h0);
        send_op(OP_REMOVE, 16'h1234, 32'h0, 8'h0, 8'h0);
        send_op(OP_FIND, 16'h1234, 32'h0, 8'h0, 8'h0);
        // removing the head shifts the rest down
        send_op(OP_REMOVE, 16'h0000, 32'h0, 8'h0, 8'h0);
        // fill the table to the top
        for (int i = 0; i < DEPTH - 2; i++)
            send_op(OP_ADD, SEQ_W'(16'h0100 + i), $urandom, RETRY_W'(i), LEN_W'(i * 4));
        // full table: the length check still comes first
        send_op(OP_ADD, 16'h0200, 32'h1, 8'h1, 8'd1);
        send_op(OP_ADD, 16'h0201, 32'h1, 8'h1, 8'd200);
        send_op(OP_FIND, 16'h010D, 32'h0, 8'h0, 8'h0);
        send_op(OP_CLEAR, 16'h0000, 32'h0, 8'h0, 8'h0);

        // Random phases, each under its own length limit, extremes first.
        limit_plan[0] = 8'd255;
        limit_plan[1] = 8'd0;
        limit_plan[2] = 8'd1;
        limit_plan[3] = LEN_W'($urandom_range(2, 254));
        limit_plan[4] = 8'd128;
        limit_plan[5] = 8'd32;
        for (int p = 0; p < PHASES; p++) begin
            program_len_limit(limit_plan[p]);
            // one whole phase runs without idle cycles on either side
            calm     = (p == 3);
            key_base = SEQ_W'($urandom);
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_op(limit_plan[p], key_base);
        end
        calm = 1'b0;

        // drain, then give a stray result time to show up
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (DEPTH + 8) @(negedge i_clk);

        $display("Covered %0d operations under %0d length limits, including full-table,",
                 items_sent, limits_used);
        $display("oversize and duplicate-key cases; %0d results compared, %0d lookup hits.",
                 results, hits);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
